### rtl/srsw_pkg.sv
// Shared types and constants for the sine row shift warp block.
`default_nettype none

package srsw_pkg;

    // Pixel and shift widths
    localparam int PIX_W = 24;
    localparam int SHIFT_W = 6;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 6'd63;

    // Sine table format: Q0.15 magnitudes
    localparam int SINE_W = 15;
    localparam logic [SINE_W-1:0] SINE_PEAK = 15'd32767;

    // Fixed-point constants: 2^32/(200*pi) and pi in Q30
    localparam logic [22:0] CENTIRAD_Q32 = 23'd6835653;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] TAYLOR_DEN [5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP = 2'd1;
    localparam logic [SHIFT_W-1:0] AMP_RESET = 6'd10;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Classified pixel item handed from front to back
    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic [SHIFT_W-1:0] col_sat;     // column, saturated at SHIFT_MAX
        logic               row_end;     // includes forced split on long rows
        logic               frame_start;
    } item_t;

    // Configuration write
    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_wr_t;

    typedef enum logic {
        BK_RUN,
        BK_TABLE
    } back_state_t;

endpackage

`default_nettype wire

### rtl/sine_row_shift_warp.sv
// Top level of the horizontal sine wave row shift warp.
//
// Pixels enter on the s_ stream in raster order: tdata carries red, green,
// blue; tlast marks the last pixel of a row; tuser marks the first pixel of
// a frame and restarts the phase. Each row is moved sideways by
// s = trunc(amplitude * sin(phase)); the phase advances by phase_step/100
// radians per row. Warped pixels leave on the m_ stream, tlast marking the
// last pixel of a row and tuser the last pixel caused by one input item.
// Registers are to be written through cfg_valid/cfg_index/cfg_data only
// while idle; the block does not enforce this. cfg_ready is always high.
// Throughput: one pixel per cycle inside a row unless the output stalls. The
// first pixel of each row waits for the sine table read and the amplitude
// multiply. A row end with s >= 0 flushes min(s, column) + 1 pixels, one per
// cycle unless the output stalls. With the queue empty, an input item passes
// through a queue slot and the output register on its way out; a four-entry
// queue lets the input side keep running during the row start lookup and the
// flush bursts. A stalled receiver holds the output register and backs up
// through the queue to s_tready. Reset clears columns, phase and all valid
// flags; amplitude resets to 10 and phase_step to 0.
`default_nettype none

module sine_row_shift_warp #(
    parameter int WINDOW_DEPTH     = 64,
    parameter int PHASE_BITS       = 24,
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int MAX_ROW_WIDTH    = 4096
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // red [7:0], green [15:8], blue [23:16]
    input  wire logic [srsw_pkg::PIX_W-1:0]       s_tdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic                             s_tlast,
    // frame_start [0]
    input  wire logic                             s_tuser,
    // out_red [7:0], out_green [15:8], out_blue [23:16]
    output logic [srsw_pkg::PIX_W-1:0]            m_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic                                  m_tlast,
    // burst_last [0]
    output logic                                  m_tuser,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [srsw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [srsw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    srsw_pkg::item_t   push_item;
    srsw_pkg::item_t   head_item;
    srsw_pkg::cfg_wr_t cfg;
    logic              q_ready;
    logic              q_push;
    logic              q_valid;
    logic              q_pop;

    // Configuration writes are taken at once
    assign cfg_ready = 1'b1;
    always_comb
    begin
        cfg.valid = cfg_valid;
        cfg.index = cfg_index;
        cfg.data  = cfg_data;
    end

    srsw_front #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    srsw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .ready     (q_ready),
        .valid     (q_valid),
        .head      (head_item),
        .pop       (q_pop)
    );

    srsw_back #(
        .WINDOW_DEPTH     (WINDOW_DEPTH),
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

### rtl/srsw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module srsw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/srsw_front.sv
// Front end: accepts pixels, tracks the input column and classifies each item.
`default_nettype none

module srsw_front #(
    parameter int MAX_ROW_WIDTH = 4096
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [srsw_pkg::PIX_W-1:0]  s_tdata,
    input  wire logic                        s_tlast,
    input  wire logic                        s_tuser,
    input  wire logic                        q_ready,
    output logic                             q_push,
    output srsw_pkg::item_t                  q_item
);

    localparam int COL_W = $clog2(MAX_ROW_WIDTH);
    localparam int CMP_W = (COL_W > srsw_pkg::SHIFT_W) ? COL_W : srsw_pkg::SHIFT_W;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col;
    logic [CMP_W-1:0] col_x;
    logic             row_end;

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

    // Column of this item; frame start restarts the row
    always_comb
    begin
        col     = s_tuser ? '0 : col_reg;
        col_x   = CMP_W'(col);
        row_end = s_tlast || (col >= COL_W'(MAX_ROW_WIDTH - 1));
    end

    // Classified item
    always_comb
    begin
        q_item.pix         = s_tdata;
        q_item.row_end     = row_end;
        q_item.frame_start = s_tuser;
        q_item.col_sat     = (col_x > CMP_W'(srsw_pkg::SHIFT_MAX)) ?
                             srsw_pkg::SHIFT_MAX : srsw_pkg::SHIFT_W'(col_x);
    end

    // Column counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (q_push)
        begin
            col_reg <= row_end ? '0 : COL_W'(col + 1'b1);
        end
    end

endmodule

`default_nettype wire

### rtl/srsw_queue.sv
// Short FIFO of classified items between front and back.
`default_nettype none

module srsw_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire srsw_pkg::item_t push_item,
    output logic                 ready,
    output logic                 valid,
    output srsw_pkg::item_t      head,
    input  wire logic            pop
);

    localparam int DEPTH = srsw_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    srsw_pkg::item_t  slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign ready = (count_reg != CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slots[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop)
            begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end
            else if (pop && !push)
            begin
                count_reg <= CNT_W'(count_reg - 1'b1);
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### rtl/srsw_back.sv
// Back end: row shift lookup, pixel window and output burst generation.
`default_nettype none

module srsw_back #(
    parameter int WINDOW_DEPTH     = 64,
    parameter int PHASE_BITS       = 24,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire srsw_pkg::cfg_wr_t           cfg,
    input  wire logic                        q_valid,
    input  wire srsw_pkg::item_t             q_item,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [srsw_pkg::PIX_W-1:0]       m_tdata,
    output logic                             m_tlast,
    output logic                             m_tuser
);

    localparam int IDX_W  = $clog2(WINDOW_DEPTH);
    localparam int TAB_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int SH     = 32 - PHASE_BITS;
    localparam int AW2    = ((IDX_W > srsw_pkg::SHIFT_W) ? IDX_W : srsw_pkg::SHIFT_W) + 1;
    localparam int LEN_W  = srsw_pkg::SHIFT_W + 1;
    localparam int SW     = srsw_pkg::SHIFT_W;
    localparam int PROD_W = srsw_pkg::SHIFT_W + srsw_pkg::SINE_W;
    localparam logic [31:0] HALF = (32'd1 << SH) >> 1;
    localparam logic [SW-1:0] SHIFT_LIM = (WINDOW_DEPTH - 1 < 63) ?
                                          SW'(WINDOW_DEPTH - 1) : srsw_pkg::SHIFT_MAX;

    typedef logic [srsw_pkg::SINE_W-1:0] tab_arr_t [SINE_TABLE_DEPTH];

    // Quarter-wave entry from an integer Taylor series to x^11 in Q30
    function automatic logic [srsw_pkg::SINE_W-1:0] sine_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] v;
        int          n;
        x   = (64'(k) * srsw_pkg::PI_Q30 + 64'(SINE_TABLE_DEPTH)) >> (TAB_W + 1);
        x2  = (x * x) >> 30;
        t   = x;
        sum = x;
        for (n = 0; n < 5; n++)
        begin
            t = ((t * x2) >> 30) / srsw_pkg::TAYLOR_DEN[n];
            if (n % 2 == 0)
            begin
                sum = sum - t;
            end
            else
            begin
                sum = sum + t;
            end
        end
        v = (sum + 64'd16384) >> 15;
        if (v > 64'(srsw_pkg::SINE_PEAK))
        begin
            v = 64'(srsw_pkg::SINE_PEAK);
        end
        return srsw_pkg::SINE_W'(v);
    endfunction

    function automatic tab_arr_t build_tab();
        tab_arr_t tab;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            tab[k] = sine_entry(k);
        end
        return tab;
    endfunction

    localparam tab_arr_t SINE_TAB = build_tab();

    // Configuration and phase state
    logic [SW-1:0]          amp_reg;
    logic [7:0]             step_reg;
    logic [PHASE_BITS-1:0]  inc_reg;
    logic [PHASE_BITS-1:0]  phase_reg;
    logic [30:0]            inc_prod;
    logic [31:0]            inc_round;

    // Back end control
    srsw_pkg::back_state_t  state_reg;
    srsw_pkg::back_state_t  state_next;
    logic                   shift_done_reg;
    logic                   shift_neg_reg;
    logic [SW-1:0]          shift_mag_reg;
    logic [LEN_W-1:0]       emit_idx_reg;
    logic [IDX_W-1:0]       wptr_reg;

    // Table lookup pipeline
    logic [1:0]                    quad_reg;
    logic                          fzero_reg;
    logic [srsw_pkg::SINE_W-1:0]   tab_q_reg;
    logic [PHASE_BITS-1:0]         phase_use;
    logic [1:0]                    quad;
    logic [TAB_W-1:0]              frac;
    logic [TAB_W-1:0]              rom_addr;
    logic [srsw_pkg::SINE_W-1:0]   mag;
    logic [PROD_W-1:0]             amp_prod;
    logic [SW-1:0]                 shift_raw;
    logic [SW-1:0]                 shift_lim;

    // Output register
    logic                          out_valid_reg;
    logic                          out_last_reg;
    logic                          out_row_end_reg;
    logic                          sel_ram_reg;
    logic [srsw_pkg::PIX_W-1:0]    out_pix_reg;
    logic [srsw_pkg::PIX_W-1:0]    ram_rdata;

    // Per-item decode
    logic                          row_start;
    logic                          need_shift;
    logic                          go;
    logic                          slot_free;
    logic                          issue;
    logic                          emit_last;
    logic                          use_ram;
    logic                          ram_re;
    logic [LEN_W-1:0]              burst_len;
    logic [IDX_W-1:0]              wr_addr;
    logic [IDX_W-1:0]              wr_addr_inc;
    logic [IDX_W-1:0]              raddr;
    logic [AW2-1:0]                wa_x;
    logic [AW2-1:0]                sm_x;

    // Per-row phase increment, rounded
    always_comb
    begin
        inc_prod  = 31'(step_reg) * 31'(srsw_pkg::CENTIRAD_Q32);
        inc_round = 32'(inc_prod) + HALF;
    end

    // Sine table address from the phase at row start
    always_comb
    begin
        phase_use = q_item.frame_start ? '0 : phase_reg;
        quad      = phase_use[PHASE_BITS-1 -: 2];
        frac      = phase_use[PHASE_BITS-3 -: TAB_W];
        rom_addr  = quad[0] ? TAB_W'(TAB_W'(0) - frac) : frac;
    end

    // Shift magnitude from table value and amplitude
    always_comb
    begin
        mag       = (quad_reg[0] && fzero_reg) ? srsw_pkg::SINE_PEAK : tab_q_reg;
        amp_prod  = PROD_W'(amp_reg) * PROD_W'(mag);
        shift_raw = amp_prod[PROD_W-1 -: SW];
        shift_lim = (shift_raw > SHIFT_LIM) ? SHIFT_LIM : shift_raw;
    end

    // Burst length and window addressing for the head item
    always_comb
    begin
        row_start  = (q_item.col_sat == '0);
        need_shift = row_start && !shift_done_reg;
        go         = (state_reg == srsw_pkg::BK_RUN) && q_valid && !need_shift;
        slot_free  = !out_valid_reg || m_tready;

        if (shift_neg_reg)
        begin
            burst_len = LEN_W'(1);
        end
        else if (q_item.row_end)
        begin
            burst_len = LEN_W'(((q_item.col_sat < shift_mag_reg) ?
                                q_item.col_sat : shift_mag_reg)) + LEN_W'(1);
        end
        else
        begin
            burst_len = (q_item.col_sat >= shift_mag_reg) ? LEN_W'(1) : '0;
        end

        emit_last = (LEN_W'(emit_idx_reg + 1'b1) == burst_len);
        issue     = go && (burst_len != '0) && slot_free;
        q_pop     = go && ((burst_len == '0) || (slot_free && emit_last));

        wr_addr     = row_start ? '0 : wptr_reg;
        wr_addr_inc = (wr_addr == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : IDX_W'(wr_addr + 1'b1);

        // Negative shift reads history; left clamp lands on column 0
        use_ram = shift_neg_reg && (q_item.col_sat != '0);
        wa_x    = AW2'(wr_addr);
        sm_x    = AW2'(shift_mag_reg);
        if (q_item.col_sat <= shift_mag_reg)
        begin
            raddr = '0;
        end
        else if (wa_x >= sm_x)
        begin
            raddr = IDX_W'(wa_x - sm_x);
        end
        else
        begin
            raddr = IDX_W'(wa_x + AW2'(WINDOW_DEPTH) - sm_x);
        end
        ram_re = issue && use_ram;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srsw_pkg::BK_RUN:
            begin
                if (q_valid && need_shift)
                begin
                    state_next = srsw_pkg::BK_TABLE;
                end
            end
            srsw_pkg::BK_TABLE:
            begin
                state_next = srsw_pkg::BK_RUN;
            end
            default:
            begin
                state_next = srsw_pkg::BK_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srsw_pkg::BK_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers and increment
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg  <= srsw_pkg::AMP_RESET;
            step_reg <= '0;
            inc_reg  <= '0;
        end
        else
        begin
            inc_reg <= PHASE_BITS'(inc_round >> SH);
            if (cfg.valid)
            begin
                case (cfg.index)
                    srsw_pkg::CFG_AMPLITUDE:  amp_reg  <= cfg.data[SW-1:0];
                    srsw_pkg::CFG_PHASE_STEP: step_reg <= cfg.data;
                    default:                  ;
                endcase
            end
        end
    end

    // Row, phase and burst control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= '0;
            shift_done_reg <= 1'b0;
            shift_neg_reg  <= 1'b0;
            shift_mag_reg  <= '0;
            emit_idx_reg   <= '0;
            wptr_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if ((state_reg == srsw_pkg::BK_RUN) && q_valid && need_shift)
            begin
                phase_reg <= phase_use;
            end
            if (state_reg == srsw_pkg::BK_TABLE)
            begin
                shift_mag_reg  <= shift_lim;
                shift_neg_reg  <= quad_reg[1] && (shift_lim != '0);
                shift_done_reg <= 1'b1;
            end
            if (q_pop)
            begin
                emit_idx_reg   <= '0;
                shift_done_reg <= 1'b0;
                wptr_reg       <= wr_addr_inc;
                if (q_item.row_end)
                begin
                    phase_reg <= PHASE_BITS'(phase_reg + inc_reg);
                end
            end
            else if (issue)
            begin
                emit_idx_reg <= LEN_W'(emit_idx_reg + 1'b1);
            end
            if (issue)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Table read and output payload
    always_ff @(posedge clk)
    begin
        if ((state_reg == srsw_pkg::BK_RUN) && q_valid && need_shift)
        begin
            quad_reg  <= quad;
            fzero_reg <= (frac == '0);
            tab_q_reg <= SINE_TAB[rom_addr];
        end
        if (issue)
        begin
            out_pix_reg     <= q_item.pix;
            sel_ram_reg     <= use_ram;
            out_last_reg    <= emit_last;
            out_row_end_reg <= q_item.row_end && emit_last;
        end
    end

    // Pixel window
    srsw_ram #(
        .WIDTH (srsw_pkg::PIX_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (go),
        .waddr (wr_addr),
        .wdata (q_item.pix),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = sel_ram_reg ? ram_rdata : out_pix_reg;
    assign m_tlast  = out_row_end_reg;
    assign m_tuser  = out_last_reg;

    // Checks
    a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("item popped from empty queue");

    a_table_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srsw_pkg::BK_TABLE) |=> (state_reg == srsw_pkg::BK_RUN) && shift_done_reg)
        else $error("shift lookup did not complete");

    a_neg_single: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && shift_neg_reg) |-> emit_last)
        else $error("negative shift produced more than one pixel");

    a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (raddr != wr_addr))
        else $error("window read hits the entry being written");

    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        emit_idx_reg <= LEN_W'(srsw_pkg::SHIFT_MAX))
        else $error("burst index out of range");

endmodule

`default_nettype wire
